// ----- sv/bffa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared widths, result codes and controller/datapath interface types for the
// bitmap first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int NUM_BLOCKS_DEF = 64;

  // Field widths of the request and result beats
  localparam int ACTION_W  = 1;
  localparam int RUN_LEN_W = 7;
  localparam int BLK_IDX_W = 6;
  localparam int STATUS_W  = 2;
  localparam int START_W   = 6;

  localparam logic [ACTION_W-1:0] ACT_FREE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  // Which result the datapath is to register this cycle
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_FREE,
    EMIT_NO_SPACE,
    EMIT_ALLOC
  } emit_t;

  typedef struct packed {
    logic  load;        // capture request fields
    logic  clr_wr;      // clearing pass: zero entry at pointer
    logic  free_wr;     // free request: clear named bit if in range
    logic  scan_first;  // read entry 0, reset run count
    logic  scan;        // evaluate one map bit
    logic  mark;        // set one bit of the found run
    emit_t emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic req_free;
    logic len_ok;
    logic clr_last;
    logic found;
    logic scan_last;
    logic mark_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/bffa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_ram
// Generic simple dual-port RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter  int WIDTH = 1,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/bffa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer: clearing pass, request decode, bitmap scan and run marking.
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bffa_pkg::dp_stat_t stat,
  output bffa_pkg::ctl_cmd_t      cmd
);
  import bffa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MARK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && !busy_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.req_free) begin
          cmd.free_wr = 1'b1;
          cmd.emit    = EMIT_FREE;
          state_nxt   = S_IDLE;
        end else if (!stat.len_ok) begin
          cmd.emit  = EMIT_NO_SPACE;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_first = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.found) begin
          state_nxt = S_MARK;
        end else if (stat.scan_last) begin
          cmd.emit  = EMIT_NO_SPACE;
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (stat.mark_last) begin
          cmd.emit  = EMIT_ALLOC;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// ----- sv/bffa_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_dpath
// Allocation map RAM, shared map pointer, run counter and result registers.
// ----------------------------------------------------------------------------
module bffa_dpath #(
  parameter int NUM_BLOCKS = bffa_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [bffa_pkg::ACTION_W-1:0]     in_action,
  input  wire logic [bffa_pkg::RUN_LEN_W-1:0]    in_run_length,
  input  wire logic [bffa_pkg::BLK_IDX_W-1:0]    in_block_index,
  input  wire bffa_pkg::ctl_cmd_t                cmd,
  output bffa_pkg::dp_stat_t                     stat,
  output logic                                   out_valid,
  output logic      [bffa_pkg::STATUS_W-1:0]     out_status,
  output logic      [bffa_pkg::START_W-1:0]      out_start_block
);
  import bffa_pkg::*;

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  // wide enough for a map index and a run length
  localparam int WW = (AW > RUN_LEN_W) ? AW : RUN_LEN_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

  // request fields
  logic [ACTION_W-1:0]  action_r;
  logic [RUN_LEN_W-1:0] want_r;
  logic [BLK_IDX_W-1:0] idx_r;

  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [RUN_LEN_W-1:0] run_r, run_nxt;
  logic [RUN_LEN_W-1:0] left_r, left_nxt;
  logic [START_W-1:0]   start6_r, start6_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [START_W-1:0]   out_start_r, out_start_nxt;

  logic                 ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]        ram_waddr, ram_raddr;

  logic                 idx_ok, len_ok, found;
  logic [RUN_LEN_W-1:0] run_inc;
  logic [WW-1:0]        start_w, idx_w;

  bffa_ram #(
    .WIDTH (1),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_ok  = (int'(idx_r) < NUM_BLOCKS);
  assign len_ok  = (want_r != '0) && (int'(want_r) <= NUM_BLOCKS);
  assign run_inc = run_r + RUN_LEN_W'(1);
  assign found   = cmd.scan && !ram_rdata && (run_inc == want_r);
  // run ends at the pointer, so it starts want-1 entries earlier
  assign start_w = WW'(ptr_r) + WW'(1) - WW'(want_r);
  assign idx_w   = WW'(idx_r);

  always_comb begin
    stat           = '0;
    stat.req_free  = (action_r == ACT_FREE);
    stat.len_ok    = len_ok;
    stat.clr_last  = (ptr_r == LAST_IDX);
    stat.found     = found;
    stat.scan_last = (ptr_r == LAST_IDX);
    stat.mark_last = (left_r == RUN_LEN_W'(1));
  end

  // map port: read runs one entry ahead of the bit under test
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = 1'b0;
    ram_raddr = ptr_r + AW'(1);
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end
    if (cmd.free_wr) begin
      ram_we    = idx_ok;
      ram_waddr = idx_w[AW-1:0];
    end
    if (cmd.mark) begin
      ram_we    = 1'b1;
      ram_wdata = 1'b1;
    end
    if (cmd.scan_first) begin
      ram_raddr = '0;
    end
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    run_nxt    = run_r;
    left_nxt   = left_r;
    start6_nxt = start6_r;
    if (cmd.clr_wr || cmd.mark) begin
      ptr_nxt = ptr_r + AW'(1);
    end
    if (cmd.mark) begin
      left_nxt = left_r - RUN_LEN_W'(1);
    end
    if (cmd.scan_first) begin
      ptr_nxt = '0;
      run_nxt = '0;
    end
    if (cmd.scan) begin
      run_nxt = ram_rdata ? '0 : run_inc;
      if (found) begin
        ptr_nxt    = start_w[AW-1:0];
        left_nxt   = want_r;
        start6_nxt = start_w[START_W-1:0];
      end else begin
        ptr_nxt = ptr_r + AW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt  = 1'b1;
    out_status_nxt = ST_OK;
    out_start_nxt  = '0;
    case (cmd.emit)
      EMIT_NONE: begin
        out_valid_nxt = 1'b0;
      end
      EMIT_FREE: begin
        out_status_nxt = idx_ok ? ST_OK : ST_BAD_INDEX;
      end
      EMIT_NO_SPACE: begin
        out_status_nxt = ST_NO_SPACE;
      end
      EMIT_ALLOC: begin
        out_start_nxt = start6_r;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      want_r   <= in_run_length;
      idx_r    <= in_block_index;
    end
    run_r        <= run_nxt;
    left_r       <= left_nxt;
    start6_r     <= start6_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_block = out_start_r;

endmodule
`default_nettype wire

// ----- sv/bitmap_first_fit_block_allocator_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_unit
// First-fit allocator of contiguous block runs over a one-bit-per-block map.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive in_action / in_run_length / in_block_index and raise start
//   while busy is low; the beat is taken at that edge and busy rises.
//   Allocate (action 0) scans the map from block 0 for the first run of
//   in_run_length free blocks, then sets its bits one per cycle. Free
//   (action 1) clears the single named bit.
//   Result: one beat per request, out_valid high for exactly one cycle with
//   out_status (0 ok, 1 no space, 2 bad index) and out_start_block.
//   Result path: a free, or a zero / oversized run length, is answered
//     straight from the decode state; an allocate that fails answers
//     once the scan reaches the last block; one that fits answers once
//     the scan has found the whole run and every bit of it is marked.
//   The scan reads one map bit per cycle from the single-read map RAM, and
//   marking writes one bit per cycle through its single write port.
//   busy falls in the result cycle, so the next request can be taken at the
//   edge that ends the result beat; items are taken one at a time.
//   The receiver cannot stall; results are never held.
//   Reset: a clearing pass writes every map entry free, one per cycle, so
//   busy stays high from reset until the pass has written the last entry.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_unit #(
  parameter int NUM_BLOCKS = bffa_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [bffa_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [bffa_pkg::RUN_LEN_W-1:0] in_run_length,
  input  wire logic [bffa_pkg::BLK_IDX_W-1:0] in_block_index,
  output logic                                out_valid,
  output logic      [bffa_pkg::STATUS_W-1:0]  out_status,
  output logic      [bffa_pkg::START_W-1:0]   out_start_block
);
  import bffa_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer: owns busy and every step of the datapath
  bffa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // map store, pointer / run counters and result beat registers
  bffa_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_action),
    .in_run_length   (in_run_length),
    .in_block_index  (in_block_index),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_start_block (out_start_block)
  );

endmodule
`default_nettype wire
